// File: src/assert_macros.svh
// Assertion macros shared by the framebuffer fill RTL.
// Needs clk_i and rst_ni in the scope of every module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: src/fbfd_pkg.sv
// Shared types and codes for the framebuffer fill and dirty-box unit.
// No dependencies.
package fbfd_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_SET_PIXEL = 3'd1,
    OP_FILL_RECT = 3'd2,
    OP_MARK      = 3'd3,
    OP_CLR_DIRTY = 3'd4,
    OP_READ      = 3'd5
  } op_e;

  // configuration register indexes
  localparam logic CFG_CANVAS_W = 1'b0;
  localparam logic CFG_CANVAS_H = 1'b1;

  typedef logic signed [17:0] sval_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic [31:0]        color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_pixel;
    logic        in_canvas;
    logic        is_dirty;
    logic [7:0]  box_left;
    logic [7:0]  box_top;
    logic [7:0]  box_width;
    logic [7:0]  box_height;
  } out_item_t;

  // request to the dirty-box unit
  typedef struct packed {
    logic               go;
    logic               clr;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } mark_req_t;

  // dirty box as shown on the result
  typedef struct packed {
    logic       is_dirty;
    logic [7:0] left;
    logic [7:0] top;
    logic [7:0] width;
    logic [7:0] height;
  } box_view_t;

  typedef struct packed {
    logic active;
    logic last;
  } walk_sts_t;

endpackage

// File: src/framebuffer_fill_with_dirty_region_unit.sv
// Top level of the framebuffer fill unit with dirty-box tracking.
// Depends on fbfd_pkg, fbfd_store, fbfd_raster, fbfd_dirty, assert_macros.svh.
//
// Small 2D drawing engine: owns a MaxWidth x MaxHeight store of 32-bit ARGB
// pixels and one dirty bounding box. One transaction in gives exactly one
// transaction out. The unit works on one transaction at a time and stalls
// the input until the sequencer is back in idle; a finished result sits in
// an output register, so the next transaction can be taken while it waits.
// The sequencer steps through start, walk, mark, mark apply and finish,
// skipping the states a transaction does not need; the walk drives the
// single store write port (one pixel per cycle).
// The pixel store has no reset; software clears the canvas before reading.
// The user must write canvas width and height on the configuration port only
// while idle; the block does not enforce it. Values above the maximum saturate.
`include "assert_macros.svh"

module framebuffer_fill_with_dirty_region_unit
  import fbfd_pkg::*;
#(
  parameter int MaxWidth  = 128,
  parameter int MaxHeight = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int WLim     = (MaxWidth < 255) ? MaxWidth : 255;
  localparam int HLim     = (MaxHeight < 255) ? MaxHeight : 255;
  localparam int XBits    = $clog2(WLim + 1);
  localparam int YBits    = $clog2(HLim + 1);
  localparam int Depth    = MaxWidth * MaxHeight;
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_START  = 6'b000010,
    ST_WALK   = 6'b000100,
    ST_MARK   = 6'b001000,
    ST_MAPPLY = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // ---- configuration ----
  logic [7:0]       cfg_w_q, cfg_h_q;
  logic [XBits-1:0] cur_w;
  logic [YBits-1:0] cur_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 8'd128;
      cfg_h_q <= 8'd128;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CANVAS_W: cfg_w_q <= cfg_wdata_i;
        CFG_CANVAS_H: cfg_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // live canvas size, saturated to the store geometry
  always_comb begin
    if (int'(cfg_w_q) > WLim) cur_w = XBits'(WLim);
    else                      cur_w = XBits'(cfg_w_q);
    if (int'(cfg_h_q) > HLim) cur_h = YBits'(HLim);
    else                      cur_h = YBits'(cfg_h_q);
  end

  // ---- decode of an incoming transaction ----
  logic             accept;
  sval_t            xs, ys, wsx, hsy, cws, chs, xe, ye, fx0, fy0, fx1, fy1;
  logic             inside_c, walk_c, mark_c, clr_c, rd_c;
  logic [XBits-1:0] rx0_c, rx1_c;
  logic [YBits-1:0] ry0_c, ry1_c;
  logic signed [15:0] mx_c, my_c, mw_c, mh_c;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    xs       = $signed({{2{in_data_i.pos_x[15]}}, in_data_i.pos_x});
    ys       = $signed({{2{in_data_i.pos_y[15]}}, in_data_i.pos_y});
    wsx      = $signed({{2{in_data_i.rect_w[15]}}, in_data_i.rect_w});
    hsy      = $signed({{2{in_data_i.rect_h[15]}}, in_data_i.rect_h});
    cws      = sval_t'(cur_w);
    chs      = sval_t'(cur_h);
    inside_c = (xs >= 18'sd0) && (xs < cws) && (ys >= 18'sd0) && (ys < chs);
    xe       = xs + wsx;
    ye       = ys + hsy;
    fx0      = (xs < 18'sd0) ? 18'sd0 : xs;
    fy0      = (ys < 18'sd0) ? 18'sd0 : ys;
    fx1      = (xe > cws) ? cws : xe;
    fy1      = (ye > chs) ? chs : ye;

    walk_c = 1'b0;
    mark_c = 1'b0;
    clr_c  = 1'b0;
    rd_c   = 1'b0;
    rx0_c  = XBits'(xs);
    rx1_c  = XBits'(xs + 18'sd1);
    ry0_c  = YBits'(ys);
    ry1_c  = YBits'(ys + 18'sd1);
    mx_c   = in_data_i.pos_x;
    my_c   = in_data_i.pos_y;
    mw_c   = in_data_i.rect_w;
    mh_c   = in_data_i.rect_h;

    case (op_e'(in_data_i.opcode))
      OP_CLEAR: begin
        walk_c = (cur_w != '0) && (cur_h != '0);
        mark_c = 1'b1;
        rx0_c  = '0;
        rx1_c  = cur_w;
        ry0_c  = '0;
        ry1_c  = cur_h;
        mx_c   = '0;
        my_c   = '0;
        mw_c   = 16'(cur_w);
        mh_c   = 16'(cur_h);
      end
      OP_SET_PIXEL: begin
        walk_c = inside_c;
        mark_c = inside_c;
        mw_c   = 16'sd1;
        mh_c   = 16'sd1;
      end
      OP_FILL_RECT: begin
        walk_c = (fx1 > fx0) && (fy1 > fy0);
        mark_c = 1'b1;
        rx0_c  = XBits'(fx0);
        rx1_c  = XBits'(fx1);
        ry0_c  = YBits'(fy0);
        ry1_c  = YBits'(fy1);
      end
      OP_MARK:      mark_c = 1'b1;
      OP_CLR_DIRTY: clr_c  = 1'b1;
      OP_READ: begin
        walk_c = inside_c;
        rd_c   = inside_c;
      end
      default: ;
    endcase
  end

  // ---- transaction registers ----
  logic             walk_q, mark_q, clr_q, rd_q, inc_q;
  logic [XBits-1:0] rx0_q, rx1_q;
  logic [YBits-1:0] ry0_q, ry1_q;
  logic signed [15:0] mx_q, my_q, mw_q, mh_q;
  logic [31:0]      color_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      walk_q  <= walk_c;
      mark_q  <= mark_c;
      clr_q   <= clr_c;
      rd_q    <= rd_c;
      inc_q   <= inside_c && ((op_e'(in_data_i.opcode) == OP_SET_PIXEL) ||
                              (op_e'(in_data_i.opcode) == OP_READ));
      rx0_q   <= rx0_c;
      rx1_q   <= rx1_c;
      ry0_q   <= ry0_c;
      ry1_q   <= ry1_c;
      mx_q    <= mx_c;
      my_q    <= my_c;
      mw_q    <= mw_c;
      mh_q    <= mh_c;
      color_q <= in_data_i.color;
    end
  end

  // ---- raster walker and pixel store ----
  walk_sts_t           walk_sts;
  logic [AddrBits-1:0] pix_addr;
  logic                mem_we, mem_re;
  logic [31:0]         mem_rdata;

  fbfd_raster #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight)
  ) u_raster (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == ST_START),
    .x0_i   (rx0_q),
    .x1_i   (rx1_q),
    .y0_i   (ry0_q),
    .y1_i   (ry1_q),
    .cur_w_i(cur_w),
    .sts_o  (walk_sts),
    .addr_o (pix_addr)
  );

  assign mem_we = walk_sts.active && !rd_q;
  assign mem_re = walk_sts.active && rd_q;

  fbfd_store #(
    .Depth   (Depth),
    .AddrBits(AddrBits)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (pix_addr),
    .wdata_i(color_q),
    .rdata_o(mem_rdata)
  );

  // ---- dirty box ----
  mark_req_t mreq;
  box_view_t box;

  assign mreq.go  = (state_q == ST_MARK) && mark_q;
  assign mreq.clr = (state_q == ST_MARK) && clr_q;
  assign mreq.x   = mx_q;
  assign mreq.y   = my_q;
  assign mreq.w   = mw_q;
  assign mreq.h   = mh_q;

  fbfd_dirty #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight)
  ) u_dirty (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .cur_w_i(cur_w),
    .cur_h_i(cur_h),
    .box_o  (box)
  );

  // ---- sequencer ----
  logic out_free, out_load;

  assign out_free = !out_valid_o || !out_stall_i;
  assign out_load = (state_q == ST_FIN) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (walk_c)               state_d = ST_START;
          else if (mark_c || clr_c) state_d = ST_MARK;
          else                      state_d = ST_FIN;
        end
      end
      ST_START: state_d = ST_WALK;
      ST_WALK: begin
        if (walk_sts.last) state_d = (mark_q || clr_q) ? ST_MARK : ST_FIN;
      end
      ST_MARK:   state_d = ST_MAPPLY;
      ST_MAPPLY: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // ---- output register ----
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.read_pixel <= rd_q ? mem_rdata : 32'h0;
      out_q.in_canvas  <= inc_q;
      out_q.is_dirty   <= box.is_dirty;
      out_q.box_left   <= box.left;
      out_q.box_top    <= box.top;
      out_q.box_width  <= box.width;
      out_q.box_height <= box.height;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEVER(a_we_outside_walk, mem_we && (state_q != ST_WALK), "store written outside walk")
  `ASSERT_AT(a_result_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN), "result loaded outside finish")

endmodule

// File: src/fbfd_store.sv
// Pixel store: one write port, one read port with registered data.
// Depends on nothing.
module fbfd_store #(
  parameter int Depth    = 16384,
  parameter int AddrBits = 14
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] addr_i,
  input  logic [31:0]         wdata_i,
  output logic [31:0]         rdata_o
);

  logic [31:0] mem [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/fbfd_raster.sv
// Raster walker: steps one pixel address per cycle over a clipped rectangle.
// Depends on fbfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbfd_raster
  import fbfd_pkg::*;
#(
  parameter int MaxWidth  = 128,
  parameter int MaxHeight = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [XBits-1:0]    x0_i,
  input  logic [XBits-1:0]    x1_i,
  input  logic [YBits-1:0]    y0_i,
  input  logic [YBits-1:0]    y1_i,
  input  logic [XBits-1:0]    cur_w_i,
  output walk_sts_t           sts_o,
  output logic [AddrBits-1:0] addr_o
);

  localparam int WLim     = (MaxWidth < 255) ? MaxWidth : 255;
  localparam int HLim     = (MaxHeight < 255) ? MaxHeight : 255;
  localparam int XBits    = $clog2(WLim + 1);
  localparam int YBits    = $clog2(HLim + 1);
  localparam int Depth    = MaxWidth * MaxHeight;
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;

  logic                      active_q;
  logic [XBits-1:0]          x_q, x0_q, x1_q;
  logic [YBits-1:0]          y_q, y1_q;
  logic [AddrBits-1:0]       row_q, addr_q;
  logic [XBits+YBits-1:0]    prod;
  logic [AddrBits-1:0]       base, row_next;
  logic                      row_end, col_end;

  assign prod     = y0_i * cur_w_i;
  assign base     = AddrBits'(prod) + AddrBits'(x0_i);
  assign row_next = row_q + AddrBits'(cur_w_i);
  assign row_end  = (x_q == x1_q - 1'b1);
  assign col_end  = (y_q == y1_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (start_i) begin
      active_q <= 1'b1;
    end else if (active_q && row_end && col_end) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x0_i;
      x0_q   <= x0_i;
      x1_q   <= x1_i;
      y_q    <= y0_i;
      y1_q   <= y1_i;
      row_q  <= base;
      addr_q <= base;
    end else if (active_q) begin
      if (row_end) begin
        x_q    <= x0_q;
        y_q    <= y_q + 1'b1;
        row_q  <= row_next;
        addr_q <= row_next;
      end else begin
        x_q    <= x_q + 1'b1;
        addr_q <= addr_q + 1'b1;
      end
    end
  end

  assign sts_o.active = active_q;
  assign sts_o.last   = active_q && row_end && col_end;
  assign addr_o       = addr_q;

  `ASSERT_AT(a_walk_in_rect, active_q |-> (x_q < x1_q) && (y_q < y1_q), "walker left its rectangle")

endmodule

// File: src/fbfd_dirty.sv
// Dirty box: clamps a mark to the canvas, then replaces or unions; clears.
// Depends on fbfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbfd_dirty
  import fbfd_pkg::*;
#(
  parameter int MaxWidth  = 128,
  parameter int MaxHeight = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mark_req_t        req_i,
  input  logic [XBits-1:0] cur_w_i,
  input  logic [YBits-1:0] cur_h_i,
  output box_view_t        box_o
);

  localparam int WLim   = (MaxWidth < 255) ? MaxWidth : 255;
  localparam int HLim   = (MaxHeight < 255) ? MaxHeight : 255;
  localparam int XBits  = $clog2(WLim + 1);
  localparam int YBits  = $clog2(HLim + 1);
  localparam int BXBits = $clog2(MaxWidth + 1);
  localparam int BYBits = $clog2(MaxHeight + 1);

  // stage 1: clamp
  logic signed [16:0] xs, ys, ws, hs, cw, ch, remx, remy;
  logic [XBits-1:0]   l_c, rw_c, l_q, rw_q;
  logic [YBits-1:0]   t_c, rh_c, t_q, rh_q;
  logic               pos_c, pend_q;

  always_comb begin
    xs    = {req_i.x[15], req_i.x};
    ys    = {req_i.y[15], req_i.y};
    ws    = {req_i.w[15], req_i.w};
    hs    = {req_i.h[15], req_i.h};
    cw    = $signed(17'(cur_w_i));
    ch    = $signed(17'(cur_h_i));
    pos_c = (ws > 17'sd0) && (hs > 17'sd0);
    if (xs < 17'sd0)   l_c = '0;
    else if (xs > cw)  l_c = cur_w_i;
    else               l_c = XBits'(xs);
    if (ys < 17'sd0)   t_c = '0;
    else if (ys > ch)  t_c = cur_h_i;
    else               t_c = YBits'(ys);
    remx  = $signed(17'(cur_w_i - l_c));
    remy  = $signed(17'(cur_h_i - t_c));
    rw_c  = (ws > remx) ? XBits'(remx) : XBits'(ws);
    rh_c  = (hs > remy) ? YBits'(remy) : YBits'(hs);
  end

  // stage 2: merge
  logic              flag_q;
  logic [BXBits-1:0] left_q, width_q, le, rwe, r_old, r_new, r_c, nl;
  logic [BYBits-1:0] top_q, height_q, te, rhe, b_old, b_new, b_c, nt;

  always_comb begin
    le    = BXBits'(l_q);
    rwe   = BXBits'(rw_q);
    te    = BYBits'(t_q);
    rhe   = BYBits'(rh_q);
    r_old = left_q + width_q;
    r_new = le + rwe;
    b_old = top_q + height_q;
    b_new = te + rhe;
    r_c   = (r_new > r_old) ? r_new : r_old;
    b_c   = (b_new > b_old) ? b_new : b_old;
    nl    = (le < left_q) ? le : left_q;
    nt    = (te < top_q) ? te : top_q;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      l_q  <= l_c;
      t_q  <= t_c;
      rw_q <= rw_c;
      rh_q <= rh_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      flag_q   <= 1'b1;
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= BXBits'(MaxWidth);
      height_q <= BYBits'(MaxHeight);
    end else if (req_i.clr) begin
      pend_q   <= 1'b0;
      flag_q   <= 1'b0;
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
    end else begin
      pend_q <= req_i.go && pos_c;
      if (pend_q) begin
        flag_q <= 1'b1;
        if (!flag_q) begin
          left_q   <= le;
          top_q    <= te;
          width_q  <= rwe;
          height_q <= rhe;
        end else begin
          left_q   <= nl;
          top_q    <= nt;
          width_q  <= r_c - nl;
          height_q <= b_c - nt;
        end
      end
    end
  end

  assign box_o.is_dirty = flag_q;
  assign box_o.left     = 8'(left_q);
  assign box_o.top      = 8'(top_q);
  assign box_o.width    = 8'(width_q);
  assign box_o.height   = 8'(height_q);

  `ASSERT_AT(a_clean_box_zero, !flag_q |-> (left_q == '0) && (width_q == '0) && (height_q == '0), "clean box not zero")
  `ASSERT_AT(a_box_in_range, 1'b1 |-> ((BXBits+1)'(left_q) + width_q) <= (BXBits+1)'(MaxWidth), "box right edge past maximum")

endmodule

// File: bench/tb.sv
// Self-checking bench for framebuffer_fill_with_dirty_region_unit.
// Holds a shadow framebuffer and dirty box, drives random and directed traffic.
// Depends on fbfd_pkg and the RTL top level only.
module tb;
  import fbfd_pkg::*;

  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          HOLDOFF_LEN = 400;
  localparam int          PHASE_ITEMS = 100;
  localparam int          RAND_PHASES = 11;
  // opcodes the block leaves undecoded
  localparam logic [2:0]  OP_UNUSED_6 = 3'd6;
  localparam logic [2:0]  OP_UNUSED_7 = 3'd7;

  // Shadow of the pixel store and dirty box; queues one expected view per
  // accepted transaction and checks results in order.
  class fb_shadow;
    localparam int MAX_W  = 128;
    localparam int MAX_H  = 128;
    localparam int PIXELS = MAX_W * MAX_H;

    logic [31:0] pixels [PIXELS];
    bit          box_dirty;
    int          box_l, box_t, box_w, box_h;
    logic [7:0]  reg_w, reg_h;
    out_item_t   pending_views [$];
    int          mismatches;

    function new();
      box_dirty  = 1'b1;
      box_l      = 0;
      box_t      = 0;
      box_w      = MAX_W;
      box_h      = MAX_H;
      reg_w      = 8'd128;
      reg_h      = 8'd128;
      mismatches = 0;
    endfunction

    function int span_w();
      return (int'(reg_w) > MAX_W) ? MAX_W : int'(reg_w);
    endfunction

    function int span_h();
      return (int'(reg_h) > MAX_H) ? MAX_H : int'(reg_h);
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function bit on_canvas(int x, int y);
      return x >= 0 && x < span_w() && y >= 0 && y < span_h();
    endfunction

    function int pix_addr(int x, int y);
      return (y * span_w() + x) % PIXELS;
    endfunction

    // clamp to the canvas, then replace a clean box or union into a dirty one
    function void merge_box(int x, int y, int w, int h);
      int l, t, rw, rh, r, b;
      if (w <= 0 || h <= 0) return;
      l  = clamp(x, 0, span_w());
      t  = clamp(y, 0, span_h());
      rw = clamp(w, 0, span_w() - l);
      rh = clamp(h, 0, span_h() - t);
      if (!box_dirty) begin
        box_dirty = 1'b1;
        box_l = l;
        box_t = t;
        box_w = rw;
        box_h = rh;
        return;
      end
      r = box_l + box_w;
      if (l + rw > r) r = l + rw;
      b = box_t + box_h;
      if (t + rh > b) b = t + rh;
      if (l < box_l) box_l = l;
      if (t < box_t) box_t = t;
      box_w = r - box_l;
      box_h = b - box_t;
    endfunction

    function void apply_op(in_item_t it);
      int        x, y, w, h, x0, y0, x1, y1;
      out_item_t view;
      x = $signed(it.pos_x);
      y = $signed(it.pos_y);
      w = $signed(it.rect_w);
      h = $signed(it.rect_h);
      view = '0;
      case (it.opcode)
        OP_CLEAR: begin
          for (int i = 0; i < span_w() * span_h(); i++) pixels[i] = it.color;
          merge_box(0, 0, span_w(), span_h());
        end
        OP_SET_PIXEL: begin
          if (on_canvas(x, y)) begin
            view.in_canvas = 1'b1;
            pixels[pix_addr(x, y)] = it.color;
            merge_box(x, y, 1, 1);
          end
        end
        OP_FILL_RECT: begin
          x0 = (x < 0) ? 0 : x;
          y0 = (y < 0) ? 0 : y;
          x1 = (x + w > span_w()) ? span_w() : x + w;
          y1 = (y + h > span_h()) ? span_h() : y + h;
          for (int yy = y0; yy < y1; yy++)
            for (int xx = x0; xx < x1; xx++) pixels[pix_addr(xx, yy)] = it.color;
          merge_box(x, y, w, h);
        end
        OP_MARK: merge_box(x, y, w, h);
        OP_CLR_DIRTY: begin
          box_dirty = 1'b0;
          box_l = 0;
          box_t = 0;
          box_w = 0;
          box_h = 0;
        end
        OP_READ: begin
          if (on_canvas(x, y)) begin
            view.in_canvas  = 1'b1;
            view.read_pixel = pixels[pix_addr(x, y)];
          end
        end
        default: ;
      endcase
      view.is_dirty   = box_dirty;
      view.box_left   = 8'(box_l);
      view.box_top    = 8'(box_t);
      view.box_width  = 8'(box_w);
      view.box_height = 8'(box_h);
      pending_views.push_back(view);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_views.size() == 0) begin
        report_mismatch("result with nothing outstanding");
        return;
      end
      want = pending_views.pop_front();
      cmp_field("read_pixel", got.read_pixel, want.read_pixel);
      cmp_field("in_canvas", got.in_canvas, want.in_canvas);
      cmp_field("is_dirty", got.is_dirty, want.is_dirty);
      cmp_field("box_left", got.box_left, want.box_left);
      cmp_field("box_top", got.box_top, want.box_top);
      cmp_field("box_width", got.box_width, want.box_width);
      cmp_field("box_height", got.box_height, want.box_height);
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_item_t  out_data_o;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  fb_shadow   shadow_fb;
  int         cycle_count;
  bit         quiet;        // both sides stop idling while set
  bit         holdoff_req;  // asks the receiver for one long hold-off

  framebuffer_fill_with_dirty_region_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: stall decided at the falling edge. A hold-off request turns
  // into a long unbroken stall, counted here, so the output register fills
  // and the block pushes back on its input.
  initial begin
    int holdoff_left;
    holdoff_left = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HOLDOFF_LEN;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 26);
      end
    end
  end

  // Every accepted result goes to the scoreboard; sampled before any update
  // of this edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) shadow_fb.check_result(out_data_o);
  end

  function automatic in_item_t mk(logic [2:0] op, int x, int y, int w, int h,
                                  logic [31:0] c);
    in_item_t it;
    it.opcode = op;
    it.pos_x  = 16'(x);
    it.pos_y  = 16'(y);
    it.rect_w = 16'(w);
    it.rect_h = 16'(h);
    it.color  = c;
    return it;
  endfunction

  // Mostly well-formed traffic near the canvas with small rectangles; a
  // slice of items gets full-range coordinates and sizes as noise.
  function automatic in_item_t random_item();
    int       r, cw, ch, clear_pct;
    in_item_t it;
    cw = shadow_fb.span_w();
    ch = shadow_fb.span_h();
    clear_pct = (cw * ch <= 1024) ? 5 : 1;
    r = $urandom_range(0, 99);
    if (r < clear_pct)  it.opcode = OP_CLEAR;
    else if (r < 35)    it.opcode = OP_SET_PIXEL;
    else if (r < 55)    it.opcode = OP_FILL_RECT;
    else if (r < 70)    it.opcode = OP_MARK;
    else if (r < 78)    it.opcode = OP_CLR_DIRTY;
    else if (r < 96)    it.opcode = OP_READ;
    else                it.opcode = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
    it.pos_x  = 16'(int'($urandom_range(0, cw + 7)) - 4);
    it.pos_y  = 16'(int'($urandom_range(0, ch + 7)) - 4);
    it.rect_w = 16'(int'($urandom_range(0, 18)) - 2);
    it.rect_h = 16'(int'($urandom_range(0, 18)) - 2);
    it.color  = $urandom;
    if ($urandom_range(0, 99) < 8) begin
      it.pos_x  = 16'($urandom);
      it.pos_y  = 16'($urandom);
      it.rect_w = 16'($urandom);
      it.rect_h = 16'($urandom);
    end
    return it;
  endfunction

  // Present one transaction from the falling edge and hold it until taken.
  task send_item(in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    shadow_fb.apply_op(it);
  endtask

  task idle_gap(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    in_data_i  <= mk($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom,
                     $urandom);
    repeat (n - 1) @(negedge clk_i);
  endtask

  task offer(in_item_t it);
    send_item(it);
    if (!quiet && $urandom_range(0, 99) < 26) idle_gap($urandom_range(1, 8));
  endtask

  // Block idle: wait until no result is outstanding, then add a margin.
  task settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow_fb.pending_views.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task write_canvas(logic [7:0] w, logic [7:0] h);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CANVAS_W;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_CANVAS_H;
    cfg_wdata_i <= h;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_fb.reg_w = w;
    shadow_fb.reg_h = h;
  endtask

  initial begin
    logic [7:0] fixed_w [8];
    logic [7:0] fixed_h [8];
    logic [7:0] pw, ph;
    fixed_w = '{8'd128, 8'd1, 8'd1,   8'd128, 8'd255, 8'd0, 8'd9, 8'd128};
    fixed_h = '{8'd128, 8'd1, 8'd128, 8'd1,   8'd200, 8'd9, 8'd0, 8'd128};

    shadow_fb   = new();
    cycle_count = 0;
    quiet       = 1'b0;
    holdoff_req = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_CANVAS_W;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset canvas. The full clear comes first so that
    // every store entry is written before anything reads it.
    offer(mk(OP_CLEAR, 0, 0, 0, 0, 32'h0000_0000));
    offer(mk(OP_CLR_DIRTY, 0, 0, 0, 0, 32'h0));
    offer(mk(OP_SET_PIXEL, 0, 0, 0, 0, 32'hFFFF_FFFF));       // clean box replaced
    offer(mk(OP_SET_PIXEL, 127, 127, 0, 0, 32'h8000_0001));   // union
    offer(mk(OP_SET_PIXEL, 128, 0, 0, 0, 32'h1234_5678));     // dropped
    offer(mk(OP_SET_PIXEL, -1, 5, 0, 0, 32'h1234_5678));
    offer(mk(OP_SET_PIXEL, 5, -32768, 0, 0, 32'h1234_5678));
    offer(mk(OP_READ, 0, 0, 0, 0, 32'h0));
    offer(mk(OP_READ, 127, 127, 0, 0, 32'h0));
    offer(mk(OP_READ, 128, 0, 0, 0, 32'hFFFF_FFFF));
    offer(mk(OP_READ, 32767, -1, 0, 0, 32'h0));
    // negative corner clamps to zero but keeps the marked size
    offer(mk(OP_FILL_RECT, -5, -5, 10, 10, 32'hA5A5_A5A5));
    offer(mk(OP_READ, 4, 4, 0, 0, 32'h0));
    offer(mk(OP_READ, 5, 5, 0, 0, 32'h0));
    offer(mk(OP_FILL_RECT, 120, 120, 32767, 32767, 32'h5A5A_5A5A));
    offer(mk(OP_FILL_RECT, 10, 10, 0, 5, 32'hDEAD_BEEF));      // empty sizes
    offer(mk(OP_FILL_RECT, 10, 10, -32768, 5, 32'hDEAD_BEEF));
    offer(mk(OP_FILL_RECT, 10, 10, 5, -1, 32'hDEAD_BEEF));
    offer(mk(OP_CLR_DIRTY, 0, 0, 0, 0, 32'h0));
    offer(mk(OP_MARK, 3, 3, 0, 3, 32'h0));                     // ignored
    offer(mk(OP_MARK, 128, 128, 5, 5, 32'h0));                 // zero-size edge box
    offer(mk(OP_MARK, -32768, -32768, 32767, 32767, 32'h0));
    offer(mk(OP_UNUSED_6, 1, 1, 1, 1, 32'h0));
    offer(mk(OP_UNUSED_7, 1, 1, 1, 1, 32'h0));
    offer(mk(OP_READ, 127, 0, 0, 0, 32'h0));

    // Random phases: fixed extremes first (incl. saturated and empty canvas),
    // then random sizes, mostly small.
    for (int p = 0; p < 8 + RAND_PHASES; p++) begin
      settle();
      if (p < 8) begin
        pw = fixed_w[p];
        ph = fixed_h[p];
      end else begin
        pw = ($urandom_range(0, 99) < 15) ? 8'd128 : 8'($urandom_range(1, 40));
        ph = ($urandom_range(0, 99) < 15) ? 8'd128 : 8'($urandom_range(1, 40));
      end
      write_canvas(pw, ph);
      quiet = (p == 9);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 30) holdoff_req = 1'b1;
        offer(random_item());
      end
    end
    quiet = 1'b0;

    settle();
    repeat (20) @(posedge clk_i);
    if (shadow_fb.mismatches == 0 && shadow_fb.pending_views.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
